[rtl/nrcq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrcq_pkg
// Shared widths, request and symbol codes, and the triangular offset helper
// for the blocked range symbol count query block.
// ----------------------------------------------------------------------------
package nrcq_pkg;

    // field widths fixed by the item format
    localparam int REQ_W  = 1;
    localparam int SYM_W  = 3;
    localparam int POS_W  = 12;
    localparam int CNT_W  = 13;

    // request codes
    localparam logic [REQ_W-1:0] REQ_APPEND = 1'b0;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 1'b1;

    // symbol codes, anything above SYM_T never counts
    localparam logic [SYM_W-1:0] SYM_A = 3'd0;
    localparam logic [SYM_W-1:0] SYM_C = 3'd1;
    localparam logic [SYM_W-1:0] SYM_G = 3'd2;
    localparam logic [SYM_W-1:0] SYM_T = 3'd3;

    // number of count lanes in one table entry
    localparam int NUM_LANES = 4;

    typedef logic [CNT_W-1:0] t_count;

    // offset of column e inside a triangular block table: e*(e+1)/2
    function automatic logic [11:0] tri_offset(input logic [5:0] e);
        logic [12:0] prod;
        prod = 13'(e) * (13'(e) + 13'd1);
        return prod[12:1];
    endfunction

endpackage

[rtl/nrcq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrcq_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module nrcq_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 34816
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/nucleotide_range_count_query_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nucleotide_range_count_query_top
// Stores a base sequence in blocks with a triangular per-block table of
// A/C/G/T range counts, appends one base per item and answers range counts.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | to block  | i_in_valid / o_in_stall   | req_type, symbol, positions
//  out     | from block| o_out_valid / i_out_stall | symbol_count, span_length,
//          |           |                           | error_flag
//
//  Append at in-block column j: one table read-modify-write per range ending
//  at the new position, through the single table read port.
//  Query: both endpoints are split into block and column by reciprocal
//  multiplication, then one table read per block covered.
//  Flagged items (full store, range past loaded length) skip the table.
//  Reset clears the loaded length; table contents stay undefined until written.
//  A finished result sits in the output register while the next item is taken;
//  a new result waits in its last step while the output register is stalled.
// ----------------------------------------------------------------------------
module nucleotide_range_count_query_top #(
    parameter int BLOCK_LEN = 16,
    parameter int MAX_LEN   = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [nrcq_pkg::REQ_W-1:0]    i_req_type,
    input  logic [nrcq_pkg::SYM_W-1:0]    i_symbol,
    input  logic [nrcq_pkg::POS_W-1:0]    i_first_pos,
    input  logic [nrcq_pkg::POS_W-1:0]    i_last_pos,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [nrcq_pkg::CNT_W-1:0]    o_symbol_count,
    output logic [nrcq_pkg::CNT_W-1:0]    o_span_length,
    output logic                          o_error_flag
);

    localparam int NUM_BLK  = (MAX_LEN + BLOCK_LEN - 1) / BLOCK_LEN;
    localparam int TRI_SZ   = (BLOCK_LEN * (BLOCK_LEN + 1)) / 2;
    localparam int DEPTH    = NUM_BLK * TRI_SZ;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int LANE_W   = $clog2(BLOCK_LEN + 1);
    localparam int ENT_W    = nrcq_pkg::NUM_LANES * LANE_W;
    localparam int COL_W    = $clog2(BLOCK_LEN);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int CMP_W    = LEN_W + nrcq_pkg::POS_W;
    localparam int STEP_W   = 1;
    localparam int TRI_LAST = TRI_SZ - BLOCK_LEN;
    localparam int POS_W    = nrcq_pkg::POS_W;
    localparam int CNT_W    = nrcq_pkg::CNT_W;

    // reciprocal of the block length, exact for every position of POS_W bits
    localparam int DIV_SH   = POS_W + $clog2(BLOCK_LEN);
    localparam int DIV_MUL  = ((1 << DIV_SH) + BLOCK_LEN - 1) / BLOCK_LEN;
    localparam int PROD_W   = 2 * POS_W + 2;

    // state codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_APPEND = 3'd1;
    localparam logic [2:0] ST_AFIN   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_ADDR   = 3'd4;
    localparam logic [2:0] ST_WALK   = 3'd5;
    localparam logic [2:0] ST_QFIN   = 3'd6;
    localparam logic [2:0] ST_EMIT   = 3'd7;

    // control state
    logic [2:0]       r_state;
    logic [LEN_W-1:0] r_len;
    logic [COL_W-1:0] r_col;
    logic [ADDR_W-1:0] r_ablk;
    logic [ADDR_W-1:0] r_abase;
    logic             r_wr_vld;
    logic             r_rd_vld;
    logic             r_out_vld;

    // working registers
    logic [nrcq_pkg::SYM_W-1:0] r_sym;
    logic [ENT_W-1:0]  r_add;
    logic [COL_W-1:0]  r_i;
    logic [ADDR_W-1:0] r_wr_addr;
    logic              r_wr_fresh;
    logic [POS_W-1:0]  r_lo_pos;
    logic [POS_W-1:0]  r_hi_pos;
    logic [POS_W-1:0]  r_lo_quo;
    logic [POS_W-1:0]  r_hi_quo;
    logic [COL_W-1:0]  r_lo_rem;
    logic [COL_W-1:0]  r_hi_rem;
    logic [STEP_W-1:0] r_step;
    logic [ADDR_W-1:0] r_qbase;
    logic [ADDR_W-1:0] r_tri_e;
    logic [COL_W-1:0]  r_qs;
    logic              r_first;
    nrcq_pkg::t_count  r_acc;
    nrcq_pkg::t_count  r_res_cnt;
    nrcq_pkg::t_count  r_res_span;
    logic              r_res_err;
    nrcq_pkg::t_count  r_out_cnt;
    nrcq_pkg::t_count  r_out_span;
    logic              r_out_err;

    // table port signals
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ENT_W-1:0]  rd_data;
    logic [ENT_W-1:0]  wr_data;

    // front-end decode
    logic              accept;
    logic [POS_W-1:0]  lo_pos;
    logic [POS_W-1:0]  hi_pos;
    logic [ENT_W-1:0]  add_vec;
    logic [LANE_W-1:0] lane_val;
    logic              walk_last;
    logic              out_free;

    // endpoint split into block and column
    logic [PROD_W-1:0] lo_prod;
    logic [PROD_W-1:0] hi_prod;
    logic [POS_W-1:0]  lo_quo;
    logic [POS_W-1:0]  hi_quo;
    logic [POS_W-1:0]  lo_blk_pos;
    logic [POS_W-1:0]  hi_blk_pos;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_vld || !i_out_stall;

    // ordered query endpoints
    assign lo_pos = (i_first_pos <= i_last_pos) ? i_first_pos : i_last_pos;
    assign hi_pos = (i_first_pos <= i_last_pos) ? i_last_pos : i_first_pos;

    // one-hot lane increment for the appended base
    always_comb begin
        add_vec = '0;
        case (i_symbol)
            nrcq_pkg::SYM_A: add_vec[0*LANE_W +: LANE_W] = LANE_W'(1);
            nrcq_pkg::SYM_C: add_vec[1*LANE_W +: LANE_W] = LANE_W'(1);
            nrcq_pkg::SYM_G: add_vec[2*LANE_W +: LANE_W] = LANE_W'(1);
            nrcq_pkg::SYM_T: add_vec[3*LANE_W +: LANE_W] = LANE_W'(1);
            default:         add_vec = '0;
        endcase
    end

    // lane select of the queried symbol from the table read data
    always_comb begin
        case (r_sym)
            nrcq_pkg::SYM_A: lane_val = rd_data[0*LANE_W +: LANE_W];
            nrcq_pkg::SYM_C: lane_val = rd_data[1*LANE_W +: LANE_W];
            nrcq_pkg::SYM_G: lane_val = rd_data[2*LANE_W +: LANE_W];
            nrcq_pkg::SYM_T: lane_val = rd_data[3*LANE_W +: LANE_W];
            default:         lane_val = '0;
        endcase
    end

    // block index of both endpoints by reciprocal multiplication
    assign lo_prod    = PROD_W'(r_lo_pos) * PROD_W'(DIV_MUL);
    assign hi_prod    = PROD_W'(r_hi_pos) * PROD_W'(DIV_MUL);
    assign lo_quo     = POS_W'(lo_prod >> DIV_SH);
    assign hi_quo     = POS_W'(hi_prod >> DIV_SH);

    // first position of each endpoint's block, from the registered block index
    assign lo_blk_pos = r_lo_quo * POS_W'(BLOCK_LEN);
    assign hi_blk_pos = r_hi_quo * POS_W'(BLOCK_LEN);

    assign walk_last = (r_lo_quo == r_hi_quo);

    // table read address: previous column on append, one block per query step
    always_comb begin
        rd_en   = (r_state == ST_APPEND) || (r_state == ST_WALK);
        rd_addr = r_qbase + (walk_last ? r_tri_e : ADDR_W'(TRI_LAST))
                + (r_first ? ADDR_W'(r_qs) : '0);
        if (r_state == ST_APPEND) begin
            rd_addr = r_abase - ADDR_W'(r_col) + ADDR_W'(r_i);
        end
    end

    // new entry is the previous column's entry plus the base, or just the base
    assign wr_data = (r_wr_fresh ? '0 : rd_data) + r_add;

    nrcq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (r_wr_vld),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // control state and sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= '0;
            r_col     <= '0;
            r_ablk    <= '0;
            r_abase   <= '0;
            r_wr_vld  <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_wr_vld <= (r_state == ST_APPEND);
            r_rd_vld <= (r_state == ST_WALK);
            // output register fills on emit, empties on a transfer
            if ((r_state == ST_EMIT) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_req_type == nrcq_pkg::REQ_APPEND) begin
                            if (r_len == LEN_W'(MAX_LEN)) begin
                                r_state <= ST_EMIT;
                            end else begin
                                r_state <= ST_APPEND;
                            end
                        end else begin
                            if (CMP_W'(hi_pos) >= CMP_W'(r_len)) begin
                                r_state <= ST_EMIT;
                            end else begin
                                r_state <= ST_DIV;
                            end
                        end
                    end
                end
                ST_APPEND: begin
                    if (r_i == r_col) begin
                        r_state <= ST_AFIN;
                    end
                end
                ST_AFIN: begin
                    // advance the append position
                    r_len <= r_len + LEN_W'(1);
                    if (r_col == COL_W'(BLOCK_LEN - 1)) begin
                        r_col   <= '0;
                        r_ablk  <= r_ablk + ADDR_W'(TRI_SZ);
                        r_abase <= r_ablk + ADDR_W'(TRI_SZ);
                    end else begin
                        r_col   <= r_col + COL_W'(1);
                        r_abase <= r_abase + ADDR_W'(r_col) + ADDR_W'(1);
                    end
                    r_state <= ST_EMIT;
                end
                ST_DIV: begin
                    if (r_step == STEP_W'(1)) begin
                        r_state <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    if (walk_last) begin
                        r_state <= ST_QFIN;
                    end
                end
                ST_QFIN: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_sym      <= i_symbol;
                    r_add      <= add_vec;
                    r_i        <= '0;
                    r_lo_pos   <= lo_pos;
                    r_hi_pos   <= hi_pos;
                    r_step     <= '0;
                    r_acc      <= '0;
                    r_res_cnt  <= '0;
                    if (i_req_type == nrcq_pkg::REQ_APPEND) begin
                        r_res_span <= CNT_W'(r_len);
                        r_res_err  <= (r_len == LEN_W'(MAX_LEN));
                    end else begin
                        r_res_span <= CNT_W'(hi_pos) - CNT_W'(lo_pos) + CNT_W'(1);
                        r_res_err  <= (CMP_W'(hi_pos) >= CMP_W'(r_len));
                    end
                end
            end
            ST_APPEND: begin
                // issue read of column j-1 row i, queue write of column j row i
                r_wr_addr  <= r_abase + ADDR_W'(r_i);
                r_wr_fresh <= (r_i == r_col);
                r_i        <= r_i + COL_W'(1);
            end
            ST_AFIN: begin
                r_res_span <= CNT_W'(r_len + LEN_W'(1));
            end
            ST_DIV: begin
                // block index first, column within the block on the next cycle
                if (r_step == '0) begin
                    r_lo_quo <= lo_quo;
                    r_hi_quo <= hi_quo;
                end else begin
                    r_lo_rem <= COL_W'(r_lo_pos - lo_blk_pos);
                    r_hi_rem <= COL_W'(r_hi_pos - hi_blk_pos);
                end
                r_step <= r_step + STEP_W'(1);
            end
            ST_ADDR: begin
                r_qbase <= ADDR_W'(r_lo_quo) * ADDR_W'(TRI_SZ);
                r_tri_e <= ADDR_W'(nrcq_pkg::tri_offset(6'(r_hi_rem)));
                r_qs    <= r_lo_rem;
                r_first <= 1'b1;
            end
            ST_WALK: begin
                // next block, accumulate the block read in the previous cycle
                r_qbase  <= r_qbase + ADDR_W'(TRI_SZ);
                r_lo_quo <= r_lo_quo + POS_W'(1);
                r_first  <= 1'b0;
                if (r_rd_vld) begin
                    r_acc <= r_acc + CNT_W'(lane_val);
                end
            end
            ST_QFIN: begin
                r_res_cnt <= r_acc + CNT_W'(lane_val);
            end
            ST_EMIT: begin
                if (out_free) begin
                    r_out_cnt  <= r_res_cnt;
                    r_out_span <= r_res_span;
                    r_out_err  <= r_res_err;
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_symbol_count = r_out_cnt;
    assign o_span_length  = r_out_span;
    assign o_error_flag   = r_out_err;

endmodule

[rtl/nrcq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrcq_checker
// Port-level checks for the range count query block, bound to the top level.
// ----------------------------------------------------------------------------
module nrcq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [nrcq_pkg::CNT_W-1:0] o_symbol_count,
    input logic [nrcq_pkg::CNT_W-1:0] o_span_length,
    input logic                       o_error_flag
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_symbol_count)
            && $stable(o_span_length) && $stable(o_error_flag))
        else $error("stalled result changed");

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a count never exceeds the range it was taken over
    a_cnt_le_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_symbol_count <= o_span_length)
        else $error("count larger than span");

    // flagged items carry no count
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_flag |-> o_symbol_count == '0)
        else $error("flagged result with nonzero count");

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

endmodule

bind nucleotide_range_count_query_top nrcq_checker u_nrcq_checker (.*);
